### src/p3_triangle_basis_eval_assert.svh
// Assertion macros for the cubic triangle basis block.
// Each use states one clocked implication, gated off while reset is low.
`ifndef P3_TRIANGLE_BASIS_EVAL_ASSERT_SVH
`define P3_TRIANGLE_BASIS_EVAL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define P3TB_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define P3TB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

### src/p3tb_pkg.sv
// ----------------------------------------------------------------------------
// p3tb_pkg
// Shared constants, types and fixed-point helpers for the cubic triangle
// basis evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package p3tb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_DOF   = 10;
	localparam int NUM_ITER  = 3;
	localparam int ACC_W     = 64;
	// scaled barycentric, shifted: covers 3*(one - 2*max_ref) and 3*one
	localparam int LN_W      = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 5;
	// three times a 32-bit gradient
	localparam int D_W       = 34;
	// magnitude width of the narrow multiplier operand
	localparam int B_W       = 33;
	localparam int PP_W      = 32 + B_W;
	localparam int PROD_W    = ACC_W + B_W;

	localparam logic [3:0] LAST_DOF = 4'(NUM_DOF - 1);

	localparam int MODE_VAL = 0;
	localparam int MODE_D1  = 1;
	localparam int MODE_D2  = 2;

	localparam logic signed [ACC_W-1:0] ONE     = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;

	localparam logic [1:0] FACTOR_NODE [NUM_DOF][NUM_ITER] = '{
		'{2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd1}, '{2'd2, 2'd2, 2'd2},
		'{2'd1, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd2}, '{2'd0, 2'd2, 2'd2},
		'{2'd0, 2'd0, 2'd2}, '{2'd0, 2'd0, 2'd1}, '{2'd0, 2'd1, 2'd1},
		'{2'd0, 2'd1, 2'd2}};

	localparam logic [1:0] FACTOR_SHIFT [NUM_DOF][NUM_ITER] = '{
		'{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2},
		'{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd0, 2'd1}, '{2'd0, 2'd0, 2'd1},
		'{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd0, 2'd1},
		'{2'd0, 2'd0, 2'd0}};

	localparam logic [2:0] DOF_DENOM [NUM_DOF] = '{
		3'd6, 3'd6, 3'd6, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1};

	typedef logic [3:0] dof_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] f;
		logic signed [ACC_W-1:0] gx;
		logic signed [ACC_W-1:0] gy;
		logic signed [ACC_W-1:0] hxx;
		logic signed [ACC_W-1:0] hyy;
		logic signed [ACC_W-1:0] hxy;
	} acc_t;

	// magnitude and sign of the factor and gradients used by one iteration
	typedef struct packed {
		logic [B_W-1:0] ln_m;
		logic [B_W-1:0] dx_m;
		logic [B_W-1:0] dy_m;
		logic           ln_n;
		logic           dx_n;
		logic           dy_n;
	} ops_t;

	typedef struct packed {
		dof_t                      dof;
		logic [2:0]                mode;
		ops_t [NUM_ITER-1:0]       ops;
	} side_t;

	localparam acc_t ACC_INIT = '{f: ONE, gx: '0, gy: '0, hxx: '0, hyy: '0, hxy: '0};

	function automatic logic [ACC_W-1:0] mag64(logic signed [ACC_W-1:0] a);
		logic [ACC_W-1:0] u;
		u = a;
		return a[ACC_W-1] ? (~u + 64'd1) : u;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
			logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		return s[ACC_W-1:0];
	endfunction

	// combine the two partial products, round half away, saturate, sign
	function automatic logic signed [ACC_W-1:0] fx_round(logic [PP_W-1:0] p_lo,
			logic [PP_W-1:0] p_hi, logic neg);
		logic [PROD_W-1:0] full;
		logic [PROD_W-1:0] r;
		logic [ACC_W-1:0]  limit;
		logic [ACC_W-1:0]  m;
		full  = {p_hi, 32'd0} + {32'd0, p_lo};
		full  = full + (PROD_W'(1) << (FRAC_BITS - 1));
		r     = full >> FRAC_BITS;
		limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (r > PROD_W'(limit))
			m = limit;
		else
			m = r[ACC_W-1:0];
		return neg ? (~m + 64'd1) : m;
	endfunction

	// eight bits of long division by three; returns {remainder, quotient}
	function automatic logic [9:0] div3_step8(logic [1:0] r_in, logic [7:0] bits);
		logic [2:0] t;
		logic [1:0] r;
		logic [7:0] q;
		r = r_in;
		q = '0;
		for (int k = 7; k >= 0; k--) begin
			t = {r, bits[k]};
			if (t >= 3'd3) begin
				t    = t - 3'd3;
				q[k] = 1'b1;
			end
			r = t[1:0];
		end
		return {r, q};
	endfunction

endpackage

`default_nettype wire

### src/p3tb_iter.sv
// ----------------------------------------------------------------------------
// p3tb_iter
// One product-rule step: multiplies the running value and derivatives by one
// shifted factor and folds in the gradient terms, over four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module p3tb_iter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [1:0]      idx,
	input  wire logic            in_valid,
	input  p3tb_pkg::acc_t       in_acc,
	input  p3tb_pkg::side_t      in_side,
	output logic                 out_valid,
	output p3tb_pkg::acc_t       out_acc,
	output p3tb_pkg::side_t      out_side
);
	import p3tb_pkg::*;

	localparam int NP        = 12;
	localparam int P_HXX_LN  = 0;
	localparam int P_GX_DX   = 1;
	localparam int P_HYY_LN  = 2;
	localparam int P_GY_DY   = 3;
	localparam int P_HXY_LN  = 4;
	localparam int P_GX_DY   = 5;
	localparam int P_GY_DX   = 6;
	localparam int P_GX_LN   = 7;
	localparam int P_F_DX    = 8;
	localparam int P_GY_LN   = 9;
	localparam int P_F_DY    = 10;
	localparam int P_F_LN    = 11;

	ops_t                    op;
	logic signed [ACC_W-1:0] a_val [NP];
	logic [ACC_W-1:0]        a_m   [NP];
	logic [B_W-1:0]          b_m   [NP];
	logic                    b_n   [NP];

	logic                    valid_s1, valid_s2, valid_s3, valid_s4;
	side_t                   side_s1, side_s2, side_s3, side_s4;
	logic [PP_W-1:0]         pl_s1 [NP];
	logic [PP_W-1:0]         ph_s1 [NP];
	logic                    ng_s1 [NP];
	logic signed [ACC_W-1:0] r_s2  [NP];
	logic signed [ACC_W-1:0] f_s3, gx_s3, gy_s3, tx2_s3, ty2_s3, hxya_s3;
	logic signed [ACC_W-1:0] hxxln_s3, hyyln_s3, gydx_s3;
	acc_t                    acc_s4;

	always_comb begin
		op = in_side.ops[idx];
		a_val[P_HXX_LN] = in_acc.hxx; b_m[P_HXX_LN] = op.ln_m; b_n[P_HXX_LN] = op.ln_n;
		a_val[P_GX_DX]  = in_acc.gx;  b_m[P_GX_DX]  = op.dx_m; b_n[P_GX_DX]  = op.dx_n;
		a_val[P_HYY_LN] = in_acc.hyy; b_m[P_HYY_LN] = op.ln_m; b_n[P_HYY_LN] = op.ln_n;
		a_val[P_GY_DY]  = in_acc.gy;  b_m[P_GY_DY]  = op.dy_m; b_n[P_GY_DY]  = op.dy_n;
		a_val[P_HXY_LN] = in_acc.hxy; b_m[P_HXY_LN] = op.ln_m; b_n[P_HXY_LN] = op.ln_n;
		a_val[P_GX_DY]  = in_acc.gx;  b_m[P_GX_DY]  = op.dy_m; b_n[P_GX_DY]  = op.dy_n;
		a_val[P_GY_DX]  = in_acc.gy;  b_m[P_GY_DX]  = op.dx_m; b_n[P_GY_DX]  = op.dx_n;
		a_val[P_GX_LN]  = in_acc.gx;  b_m[P_GX_LN]  = op.ln_m; b_n[P_GX_LN]  = op.ln_n;
		a_val[P_F_DX]   = in_acc.f;   b_m[P_F_DX]   = op.dx_m; b_n[P_F_DX]   = op.dx_n;
		a_val[P_GY_LN]  = in_acc.gy;  b_m[P_GY_LN]  = op.ln_m; b_n[P_GY_LN]  = op.ln_n;
		a_val[P_F_DY]   = in_acc.f;   b_m[P_F_DY]   = op.dy_m; b_n[P_F_DY]   = op.dy_n;
		a_val[P_F_LN]   = in_acc.f;   b_m[P_F_LN]   = op.ln_m; b_n[P_F_LN]   = op.ln_n;
		for (int k = 0; k < NP; k++)
			a_m[k] = mag64(a_val[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: split the wide operand into two 32-bit halves and multiply each by the narrow operand
		for (int k = 0; k < NP; k++) begin
			pl_s1[k] <= PP_W'(a_m[k][31:0]) * PP_W'(b_m[k]);
			ph_s1[k] <= PP_W'(a_m[k][63:32]) * PP_W'(b_m[k]);
			ng_s1[k] <= a_val[k][ACC_W-1] ^ b_n[k];
		end
		side_s1 <= in_side;

		// stage 2: recombine, round and saturate each product
		for (int k = 0; k < NP; k++)
			r_s2[k] <= fx_round(pl_s1[k], ph_s1[k], ng_s1[k]);
		side_s2 <= side_s1;

		// stage 3: first level of saturating sums
		f_s3     <= r_s2[P_F_LN];
		gx_s3    <= sat_add(r_s2[P_GX_LN], r_s2[P_F_DX]);
		gy_s3    <= sat_add(r_s2[P_GY_LN], r_s2[P_F_DY]);
		tx2_s3   <= sat_add(r_s2[P_GX_DX], r_s2[P_GX_DX]);
		ty2_s3   <= sat_add(r_s2[P_GY_DY], r_s2[P_GY_DY]);
		hxya_s3  <= sat_add(r_s2[P_HXY_LN], r_s2[P_GX_DY]);
		hxxln_s3 <= r_s2[P_HXX_LN];
		hyyln_s3 <= r_s2[P_HYY_LN];
		gydx_s3  <= r_s2[P_GY_DX];
		side_s3  <= side_s2;

		// stage 4: close the second-derivative sums
		acc_s4.f   <= f_s3;
		acc_s4.gx  <= gx_s3;
		acc_s4.gy  <= gy_s3;
		acc_s4.hxx <= sat_add(hxxln_s3, tx2_s3);
		acc_s4.hyy <= sat_add(hyyln_s3, ty2_s3);
		acc_s4.hxy <= sat_add(hxya_s3, gydx_s3);
		side_s4    <= side_s3;
	end

	assign out_valid = valid_s4;
	assign out_acc   = acc_s4;
	assign out_side  = side_s4;

endmodule

`default_nettype wire

### src/p3_triangle_basis_eval.sv
// ----------------------------------------------------------------------------
// p3_triangle_basis_eval
// Cubic Lagrange basis on the reference triangle: values, gradients and
// second derivatives of all ten degrees of freedom for one point.
// ----------------------------------------------------------------------------
// Usage:
//   A point transaction is taken at a rising edge with start high and busy
//   low: mode mask, reference point and the three barycentric gradients.
//   The block then issues the ten degrees of freedom into its pipeline, one
//   a cycle, and holds busy high for the first nine of them, so a new point
//   may be offered on the cycle the tenth issues.
//   Results leave in order 0..9, one per cycle, each shown for exactly one
//   cycle with strobe high; last_dof marks the tenth.
//   From acceptance to strobe a result passes one issue stage, three
//   four-stage product-rule steps, one scaling stage, eight stages of
//   divide-by-three and one output register.
//   The receiver cannot hold results off and none is needed: the pipeline
//   never stalls. Reset clears the issue counter and all valid bits; no
//   result is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module p3_triangle_basis_eval (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         mode,
	input  wire logic [16:0]        ref_x,
	input  wire logic [16:0]        ref_y,
	input  wire logic signed [31:0] grad0_x,
	input  wire logic signed [31:0] grad0_y,
	input  wire logic signed [31:0] grad1_x,
	input  wire logic signed [31:0] grad1_y,
	input  wire logic signed [31:0] grad2_x,
	input  wire logic signed [31:0] grad2_y,
	output logic                    strobe,
	output logic [3:0]              dof_index,
	output logic signed [63:0]      basis_value,
	output logic signed [63:0]      deriv_x,
	output logic signed [63:0]      deriv_y,
	output logic signed [63:0]      deriv_xx,
	output logic signed [63:0]      deriv_yy,
	output logic signed [63:0]      deriv_xy,
	output logic                    last_dof
);
	import p3tb_pkg::*;

	localparam int NF       = 6;
	localparam int NDIV     = 8;
	localparam logic signed [LN_W-1:0] ONE_LN = LN_W'(1) << FRAC_BITS;

	typedef struct packed {
		dof_t                   dof;
		logic                   need3;
		logic [NF-1:0]          sgn;
		logic [NF-1:0][63:0]    v;
		logic [NF-1:0][63:0]    q;
		logic [NF-1:0][1:0]     r;
	} div_t;

	logic                    accept;
	logic                    issuing_q;
	dof_t                    cnt_q;
	logic [2:0]              mode_q;
	logic signed [LN_W-1:0]  lam_q [NUM_ITER];
	logic signed [D_W-1:0]   dx_q  [NUM_ITER];
	logic signed [D_W-1:0]   dy_q  [NUM_ITER];

	logic signed [LN_W-1:0]  lam_d [NUM_ITER];
	logic signed [D_W-1:0]   dx_d  [NUM_ITER];
	logic signed [D_W-1:0]   dy_d  [NUM_ITER];
	logic signed [D_W-1:0]   gx_in [NUM_ITER];
	logic signed [D_W-1:0]   gy_in [NUM_ITER];
	logic signed [LN_W-1:0]  lam0_base;

	side_t                   side_d;
	logic signed [LN_W-1:0]  ln_v;
	logic signed [D_W-1:0]   dxs, dys;
	logic [LN_W-1:0]         ln_mag;
	logic [D_W-1:0]          dx_mag, dy_mag;
	logic [1:0]              node;

	logic                    valid_s0;
	side_t                   side_s0;

	logic                    it_valid [NUM_ITER+1];
	acc_t                    it_acc   [NUM_ITER+1];
	side_t                   it_side  [NUM_ITER+1];

	logic                    dvalid_s [NDIV+1];
	div_t                    dstage_s [NDIV+1];

	logic signed [63:0]      fld   [NF];
	logic [63:0]             fmag  [NF];
	logic [2:0]              den;
	logic [63:0]             res   [NF];

	logic                    strobe_q;
	dof_t                    dof_q;
	logic signed [63:0]      out_q [NF];

	assign busy   = issuing_q && (cnt_q != LAST_DOF);
	assign accept = start && !busy;

	// scaled barycentrics and gradients of the offered point
	always_comb begin
		lam0_base = ONE_LN - LN_W'(ref_x) - LN_W'(ref_y);
		lam_d[0]  = lam0_base + (lam0_base <<< 1);
		lam_d[1]  = LN_W'(ref_x) + (LN_W'(ref_x) << 1);
		lam_d[2]  = LN_W'(ref_y) + (LN_W'(ref_y) << 1);
		gx_in[0]  = D_W'(grad0_x);
		gx_in[1]  = D_W'(grad1_x);
		gx_in[2]  = D_W'(grad2_x);
		gy_in[0]  = D_W'(grad0_y);
		gy_in[1]  = D_W'(grad1_y);
		gy_in[2]  = D_W'(grad2_y);
		for (int i = 0; i < NUM_ITER; i++) begin
			dx_d[i] = gx_in[i] + (gx_in[i] <<< 1);
			dy_d[i] = gy_in[i] + (gy_in[i] <<< 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			cnt_q     <= '0;
		end else if (accept) begin
			issuing_q <= 1'b1;
			cnt_q     <= '0;
		end else if (issuing_q) begin
			if (cnt_q == LAST_DOF)
				issuing_q <= 1'b0;
			else
				cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			for (int i = 0; i < NUM_ITER; i++) begin
				lam_q[i] <= lam_d[i];
				dx_q[i]  <= dx_d[i];
				dy_q[i]  <= dy_d[i];
			end
		end
	end

	// pick the factor and gradients of each step for the issuing dof
	always_comb begin
		side_d.dof  = cnt_q;
		side_d.mode = mode_q;
		for (int i = 0; i < NUM_ITER; i++) begin
			node   = FACTOR_NODE[cnt_q][i];
			ln_v   = lam_q[node] - (LN_W'(FACTOR_SHIFT[cnt_q][i]) << FRAC_BITS);
			dxs    = dx_q[node];
			dys    = dy_q[node];
			ln_mag = ln_v[LN_W-1] ? (~ln_v + LN_W'(1)) : ln_v;
			dx_mag = dxs[D_W-1] ? (~dxs + D_W'(1)) : dxs;
			dy_mag = dys[D_W-1] ? (~dys + D_W'(1)) : dys;
			side_d.ops[i].ln_m = B_W'(ln_mag);
			side_d.ops[i].dx_m = dx_mag[B_W-1:0];
			side_d.ops[i].dy_m = dy_mag[B_W-1:0];
			side_d.ops[i].ln_n = ln_v[LN_W-1];
			side_d.ops[i].dx_n = dxs[D_W-1];
			side_d.ops[i].dy_n = dys[D_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s0 <= 1'b0;
		else
			valid_s0 <= issuing_q;
	end

	always_ff @(posedge clk) begin
		side_s0 <= side_d;
	end

	assign it_valid[0] = valid_s0;
	assign it_acc[0]   = ACC_INIT;
	assign it_side[0]  = side_s0;

	for (genvar g = 0; g < NUM_ITER; g++) begin : g_iter
		p3tb_iter u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (2'(g)),
			.in_valid  (it_valid[g]),
			.in_acc    (it_acc[g]),
			.in_side   (it_side[g]),
			.out_valid (it_valid[g+1]),
			.out_acc   (it_acc[g+1]),
			.out_side  (it_side[g+1])
		);
	end

	// gate by mode, take magnitudes and fold in half the denominator
	always_comb begin
		fld[0] = it_side[NUM_ITER].mode[MODE_VAL] ? it_acc[NUM_ITER].f   : '0;
		fld[1] = it_side[NUM_ITER].mode[MODE_D1]  ? it_acc[NUM_ITER].gx  : '0;
		fld[2] = it_side[NUM_ITER].mode[MODE_D1]  ? it_acc[NUM_ITER].gy  : '0;
		fld[3] = it_side[NUM_ITER].mode[MODE_D2]  ? it_acc[NUM_ITER].hxx : '0;
		fld[4] = it_side[NUM_ITER].mode[MODE_D2]  ? it_acc[NUM_ITER].hyy : '0;
		fld[5] = it_side[NUM_ITER].mode[MODE_D2]  ? it_acc[NUM_ITER].hxy : '0;
		den    = DOF_DENOM[it_side[NUM_ITER].dof];
		for (int k = 0; k < NF; k++)
			fmag[k] = mag64(fld[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NDIV; k++)
				dvalid_s[k] <= 1'b0;
		end else begin
			dvalid_s[0] <= it_valid[NUM_ITER];
			for (int k = 0; k < NDIV; k++)
				dvalid_s[k+1] <= dvalid_s[k];
		end
	end

	always_ff @(posedge clk) begin
		dstage_s[0].dof   <= it_side[NUM_ITER].dof;
		dstage_s[0].need3 <= (den == 3'd6);
		for (int k = 0; k < NF; k++) begin
			dstage_s[0].sgn[k] <= fld[k][63];
			// pass through for one, halve for two, divide by six as halve then divide by three
			if (den == 3'd1)
				dstage_s[0].v[k] <= fmag[k];
			else
				dstage_s[0].v[k] <= (fmag[k] + 64'(den >> 1)) >> 1;
			dstage_s[0].q[k] <= '0;
			dstage_s[0].r[k] <= '0;
		end
	end

	for (genvar s = 0; s < NDIV; s++) begin : g_div
		logic [NF-1:0][9:0] div_step;

		always_comb begin
			for (int k = 0; k < NF; k++)
				div_step[k] = div3_step8(dstage_s[s].r[k], dstage_s[s].v[k][63-8*s -: 8]);
		end

		always_ff @(posedge clk) begin
			dstage_s[s+1].dof   <= dstage_s[s].dof;
			dstage_s[s+1].need3 <= dstage_s[s].need3;
			dstage_s[s+1].sgn   <= dstage_s[s].sgn;
			dstage_s[s+1].v     <= dstage_s[s].v;
			for (int k = 0; k < NF; k++) begin
				dstage_s[s+1].r[k] <= div_step[k][9:8];
				dstage_s[s+1].q[k] <= {dstage_s[s].q[k][55:0], div_step[k][7:0]};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NF; k++)
			res[k] = dstage_s[NDIV].need3 ? dstage_s[NDIV].q[k] : dstage_s[NDIV].v[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= dvalid_s[NDIV];
	end

	always_ff @(posedge clk) begin
		dof_q <= dstage_s[NDIV].dof;
		for (int k = 0; k < NF; k++)
			out_q[k] <= dstage_s[NDIV].sgn[k] ? (~res[k] + 64'd1) : res[k];
	end

	assign strobe      = strobe_q;
	assign dof_index   = dof_q;
	assign last_dof    = (dof_q == LAST_DOF);
	assign basis_value = out_q[0];
	assign deriv_x     = out_q[1];
	assign deriv_y     = out_q[2];
	assign deriv_xx    = out_q[3];
	assign deriv_yy    = out_q[4];
	assign deriv_xy    = out_q[5];

endmodule

`default_nettype wire

### src/p3tb_checker.sv
// ----------------------------------------------------------------------------
// p3tb_checker
// Port-level checks on issue and result ordering of the basis evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "p3_triangle_basis_eval_assert.svh"

module p3tb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [3:0] dof_index,
	input wire logic       last_dof
);
	import p3tb_pkg::*;

	// an accepted transaction keeps the input side closed for the next cycle
	`P3TB_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy low after accept")

	// last_dof marks exactly the final degree of freedom
	`P3TB_ASSERT_NOW(a_last_flag, clk, arst_n, strobe, last_dof == (dof_index == LAST_DOF), "last_dof mismatch")

	// a run of results is unbroken and counts up
	`P3TB_ASSERT_NEXT(a_run_order, clk, arst_n, strobe && !last_dof, strobe && (dof_index == $past(dof_index) + 4'd1), "result run broken")

	// a run always opens on degree of freedom zero
	`P3TB_ASSERT_NEXT(a_run_start, clk, arst_n, !strobe, !strobe || (dof_index == 4'd0), "run does not start at zero")

endmodule

bind p3_triangle_basis_eval p3tb_checker u_p3tb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.dof_index (dof_index),
	.last_dof  (last_dof)
);

`default_nettype wire
